FILE: rtl/core/het_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package het_pkg;

  localparam int unsigned KeyW       = 32;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned BucketsDef = 128;
  localparam int unsigned SlotsDef   = 4;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_DELETE = 2'd1,
    OP_TICK   = 2'd2,
    OP_SCAN   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_e;

endpackage

`default_nettype wire

FILE: rtl/core/het_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface het_in_if;
  import het_pkg::*;

  logic             valid;
  logic             ready;
  op_e              opcode;
  logic [KeyW-1:0]  key;
  logic [TimeW-1:0] duration;

  modport source (output valid, output opcode, output key, output duration, input ready);
  modport sink   (input valid, input opcode, input key, input duration, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/het_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface het_out_if;
  import het_pkg::*;

  logic            valid;
  logic            ready;
  status_e         status;
  logic            expired_valid;
  logic [KeyW-1:0] expired_key;

  modport source (output valid, output status, output expired_valid, output expired_key,
                  input ready);
  modport sink   (input valid, input status, input expired_valid, input expired_key,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/het_hash.sv
`timescale 1ns / 1ps
`default_nettype none

// key mod BUCKETS by reciprocal multiply and one correction, two register stages
// key_i must hold steady for both cycles
module het_hash #(
  parameter int unsigned BUCKETS = het_pkg::BucketsDef
) (
  input  logic                        clk_i,
  input  logic [het_pkg::KeyW-1:0]    key_i,
  output logic [$clog2(BUCKETS)-1:0]  bucket_o
);
  import het_pkg::*;

  localparam int unsigned BW    = $clog2(BUCKETS);
  localparam int unsigned Shift = KeyW + BW;
  localparam int unsigned ProdW = 2 * KeyW + 1;
  localparam logic [KeyW:0] Recip = (KeyW + 1)'((64'd1 << Shift) / 64'(BUCKETS));
  localparam logic [KeyW-1:0] Modulus = KeyW'(BUCKETS);

  logic [ProdW-1:0] prod;
  logic [KeyW-1:0]  quo_q;
  logic [KeyW-1:0]  quo_mul;
  logic [KeyW-1:0]  rem;
  logic [KeyW-1:0]  rem_fix;
  logic [BW-1:0]    bucket_q;

  // estimated quotient is exact or one low
  assign prod = ProdW'(key_i) * ProdW'(Recip);

  always_ff @(posedge clk_i) begin
    quo_q <= KeyW'(prod >> Shift);
  end

  assign quo_mul = quo_q * Modulus;
  assign rem     = key_i - quo_mul;
  assign rem_fix = (rem >= Modulus) ? (rem - Modulus) : rem;

  always_ff @(posedge clk_i) begin
    bucket_q <= BW'(rem_fix);
  end

  assign bucket_o = bucket_q;

endmodule

`default_nettype wire

FILE: rtl/core/hashed_expiry_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// keyed expiry table with round-robin scan
// req_i carries one operation per beat: update, delete, tick or scan, with key
// and duration; rsp_o returns exactly one beat per request, in order, with the
// status and, for a scan, the key of an entry that expired
// each bucket is one row of a single-port-read, single-port-write memory with
// a registered read: fill count, keys and deadlines of all slots
// steps from accepting a request to being ready for the next one:
//   update, delete  key mod BUCKETS, row read, row rewrite
//   scan            row read, row rewrite
//   tick            time step only, no row access
// the read-modify-write of one row finishes before the next request enters,
// so accesses to the same row never overlap
// the response beat appears in the cycle after the row rewrite; while a beat
// waits in the output register the next request is still accepted and runs up
// to its final step, where it holds until the receiver takes the waiting beat
// after reset the block sweeps the memory row by row, writing every
// row's fill count to zero, and takes no request during that sweep
module hashed_expiry_table_unit #(
  parameter int unsigned BUCKETS = het_pkg::BucketsDef,
  parameter int unsigned SLOTS   = het_pkg::SlotsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  het_in_if.sink          req_i,
  het_out_if.source       rsp_o
);
  import het_pkg::*;

  localparam int unsigned BW = $clog2(BUCKETS);
  localparam int unsigned CW = $clog2(SLOTS + 1);

  typedef struct packed {
    logic [CW-1:0]                cnt;
    logic [SLOTS-1:0][KeyW-1:0]   key;
    logic [SLOTS-1:0][TimeW-1:0]  dl;
  } row_t;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_HASH1 = 6'b000100,
    S_HASH2 = 6'b001000,
    S_READ  = 6'b010000,
    S_EDIT  = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [BW-1:0]     clr_q;
  logic [TimeW-1:0]  time_now_q;
  logic [BW-1:0]     scan_q;
  logic              rsp_valid_q;

  // request payload held for the whole operation
  op_e               op_q;
  logic [KeyW-1:0]   key_q;
  logic [TimeW-1:0]  dur_q;
  logic [BW-1:0]     row_addr_q;

  logic [BW-1:0]     hash_bucket;
  logic [BW-1:0]     raddr;
  logic [BW-1:0]     mem_waddr;
  logic              mem_we;
  row_t              mem_wdata;
  row_t              rd_row_q;
  row_t              row_mem [BUCKETS];

  logic              accept;
  logic              edit_go;

  logic [SLOTS-1:0]  hit;
  logic [SLOTS-1:0]  first;
  logic [SLOTS-1:0]  pre;
  logic              any_hit;
  logic [KeyW-1:0]   found_key;
  row_t              shifted;
  row_t              new_row;
  status_e           status;
  logic              exp_valid;
  logic [KeyW-1:0]   exp_key;

  status_e           rsp_status_q;
  logic              rsp_exp_valid_q;
  logic [KeyW-1:0]   rsp_exp_key_q;

  het_hash #(
    .BUCKETS (BUCKETS)
  ) u_hash (
    .clk_i    (clk_i),
    .key_i    (key_q),
    .bucket_o (hash_bucket)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  // final step may only run when the output register is free or being drained
  assign edit_go     = (state_q == S_EDIT) && (!rsp_valid_q || rsp_o.ready);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == BW'(BUCKETS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          unique case (req_i.opcode)
            OP_UPDATE, OP_DELETE: state_d = S_HASH1;
            OP_SCAN:              state_d = S_READ;
            OP_TICK:              state_d = S_EDIT;
            default:              state_d = S_IDLE;
          endcase
        end
      end
      S_HASH1: state_d = S_HASH2;
      S_HASH2: state_d = S_READ;
      S_READ:  state_d = S_EDIT;
      S_EDIT: begin
        if (edit_go) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      time_now_q  <= '0;
      scan_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + BW'(1);
      if (edit_go && op_q == OP_TICK) time_now_q <= time_now_q + TimeW'(1);
      if (edit_go && op_q == OP_SCAN) begin
        scan_q <= (scan_q == BW'(BUCKETS - 1)) ? '0 : scan_q + BW'(1);
      end
      if (edit_go) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= req_i.opcode;
      key_q <= req_i.key;
      dur_q <= req_i.duration;
    end
    if (state_q == S_READ) row_addr_q <= raddr;
    if (edit_go) begin
      rsp_status_q    <= status;
      rsp_exp_valid_q <= exp_valid;
      rsp_exp_key_q   <= exp_key;
    end
  end

  // bucket row memory
  assign raddr     = (op_q == OP_SCAN) ? scan_q : hash_bucket;
  assign mem_we    = (state_q == S_CLEAR) || (edit_go && op_q != OP_TICK);
  assign mem_waddr = (state_q == S_CLEAR) ? clr_q : row_addr_q;
  assign mem_wdata = (state_q == S_CLEAR) ? '0 : new_row;

  always_ff @(posedge clk_i) begin
    if (mem_we) row_mem[mem_waddr] <= mem_wdata;
    if (state_q == S_READ) rd_row_q <= row_mem[raddr];
  end

  // match per slot: key equality, or deadline strictly below now for a scan
  always_comb begin
    logic acc;
    hit       = '0;
    first     = '0;
    pre       = '0;
    found_key = '0;
    shifted   = rd_row_q;
    acc       = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (CW'(i) < rd_row_q.cnt) begin
        hit[i] = (op_q == OP_SCAN) ? (time_now_q > rd_row_q.dl[i])
                                   : (rd_row_q.key[i] == key_q);
      end
    end
    // oldest match wins; everything from it on moves forward by one
    for (int i = 0; i < SLOTS; i++) begin
      first[i] = hit[i] & ~acc;
      acc      = acc | hit[i];
      pre[i]   = acc;
    end
    any_hit = acc;
    for (int i = 0; i < SLOTS; i++) begin
      if (first[i]) found_key = found_key | rd_row_q.key[i];
      if (pre[i] && (i < SLOTS - 1)) begin
        shifted.key[i] = rd_row_q.key[(i < SLOTS - 1) ? i + 1 : i];
        shifted.dl[i]  = rd_row_q.dl[(i < SLOTS - 1) ? i + 1 : i];
      end
    end
    shifted.cnt = rd_row_q.cnt - CW'(any_hit);
  end

  // row rewrite and response fields
  always_comb begin
    new_row   = shifted;
    status    = ST_OK;
    exp_valid = 1'b0;
    exp_key   = '0;
    unique case (op_q)
      OP_UPDATE: begin
        // only a bucket that is full and lacks the key rejects the update
        if (shifted.cnt == CW'(SLOTS)) begin
          status  = ST_FULL;
          new_row = rd_row_q;
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (CW'(i) == shifted.cnt) begin
              new_row.key[i] = key_q;
              new_row.dl[i]  = time_now_q + dur_q;
            end
          end
          new_row.cnt = shifted.cnt + CW'(1);
        end
      end
      OP_DELETE: begin
        if (!any_hit) status = ST_MISSING;
      end
      OP_SCAN: begin
        exp_valid = any_hit;
        exp_key   = found_key;
      end
      OP_TICK: begin
        new_row = rd_row_q;
      end
      default: begin
        new_row = rd_row_q;
      end
    endcase
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = rsp_status_q;
  assign rsp_o.expired_valid = rsp_exp_valid_q;
  assign rsp_o.expired_key   = rsp_exp_key_q;

  // a rewritten row never holds more entries than a bucket has slots
  a_row_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (mem_wdata.cnt <= CW'(SLOTS)))
    else $error("row fill count above slot count");

  // the reciprocal reduction must land inside the table
  a_hash_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ && op_q != OP_SCAN) |-> (int'(hash_bucket) < BUCKETS))
    else $error("hashed bucket out of range");

  // the clock only moves on a finished tick
  a_time_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(time_now_q) |-> $past(edit_go && op_q == OP_TICK))
    else $error("time changed without a tick");

  // a finished operation never overwrites a response still waiting
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_o.ready) |=> (rsp_valid_q && $stable(rsp_exp_key_q)
                                       && $stable(rsp_status_q)))
    else $error("waiting response overwritten");

endmodule

`default_nettype wire

FILE: tb/expiry_table_checker.sv
`timescale 1ns / 1ps

module expiry_table_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  het_in_if           req_mon,
  het_out_if          rsp_mon,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_cnt_o
);
  import het_pkg::*;

  localparam int unsigned Buckets = BucketsDef;
  localparam int unsigned Slots   = SlotsDef;

  typedef struct packed {
    status_e         status;
    logic            expired_valid;
    logic [KeyW-1:0] expired_key;
  } table_rsp_t;

  logic [TimeW-1:0] now_ms;
  int unsigned      scan_ptr;
  logic             live    [Buckets][Slots];
  logic [KeyW-1:0]  ent_key [Buckets][Slots];
  logic [TimeW-1:0] ent_dl  [Buckets][Slots];
  table_rsp_t       rsp_expect_q[$];

  function automatic int unsigned bucket_fill(int unsigned b);
    int unsigned n;
    n = 0;
    while (n < Slots && live[b][n]) n++;
    return n;
  endfunction

  // close the gap left by slot s
  function automatic void remove_slot(int unsigned b, int unsigned s);
    int unsigned n;
    n = bucket_fill(b);
    for (int unsigned i = s; i + 1 < n; i++) begin
      ent_key[b][i] = ent_key[b][i+1];
      ent_dl[b][i]  = ent_dl[b][i+1];
    end
    if (n > 0) live[b][n-1] = 1'b0;
  endfunction

  function automatic logic remove_key(int unsigned b, logic [KeyW-1:0] k);
    int unsigned n;
    n = bucket_fill(b);
    for (int unsigned i = 0; i < n; i++) begin
      if (ent_key[b][i] == k) begin
        remove_slot(b, i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic table_rsp_t predict_table_op(op_e op, logic [KeyW-1:0] k,
                                                  logic [TimeW-1:0] d);
    table_rsp_t  r;
    int unsigned b;
    int unsigned n;
    r = '{status: ST_OK, expired_valid: 1'b0, expired_key: '0};
    b = k % Buckets;
    case (op)
      OP_UPDATE: begin
        void'(remove_key(b, k));
        n = bucket_fill(b);
        if (n >= Slots) begin
          r.status = ST_FULL;
        end else begin
          ent_key[b][n] = k;
          ent_dl[b][n]  = now_ms + d;
          live[b][n]    = 1'b1;
        end
      end
      OP_DELETE: begin
        if (!remove_key(b, k)) r.status = ST_MISSING;
      end
      OP_TICK: begin
        now_ms = now_ms + 1'b1;
      end
      OP_SCAN: begin
        n = bucket_fill(scan_ptr);
        for (int unsigned i = 0; i < n; i++) begin
          if (now_ms > ent_dl[scan_ptr][i]) begin
            r.expired_valid = 1'b1;
            r.expired_key   = ent_key[scan_ptr][i];
            remove_slot(scan_ptr, i);
            break;
          end
        end
        scan_ptr = (scan_ptr + 1 >= Buckets) ? 0 : scan_ptr + 1;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    table_rsp_t exp_rsp;
    if (!rst_ni) begin
      now_ms   = '0;
      scan_ptr = 0;
      for (int unsigned b = 0; b < Buckets; b++) begin
        for (int unsigned s = 0; s < Slots; s++) live[b][s] = 1'b0;
      end
      rsp_expect_q.delete();
    end else begin
      if (req_mon.valid && req_mon.ready) begin
        exp_rsp = predict_table_op(req_mon.opcode, req_mon.key, req_mon.duration);
        rsp_expect_q.insert(rsp_expect_q.size(), exp_rsp);
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (rsp_expect_q.size() == 0) begin
          mismatch_cnt_o++;
          if (mismatch_cnt_o <= 10) begin
            $display("%0t: unexpected beat: status %0d expired_valid %0b expired_key %08h",
                     $realtime, rsp_mon.status, rsp_mon.expired_valid, rsp_mon.expired_key);
          end
        end else begin
          exp_rsp = rsp_expect_q.pop_front();
          if (rsp_mon.status !== exp_rsp.status ||
              rsp_mon.expired_valid !== exp_rsp.expired_valid ||
              rsp_mon.expired_key !== exp_rsp.expired_key) begin
            mismatch_cnt_o++;
            if (mismatch_cnt_o <= 10) begin
              $display("%0t: mismatch: status %0d/%0d expired_valid %0b/%0b key %08h/%08h",
                       $realtime, exp_rsp.status, rsp_mon.status, exp_rsp.expired_valid,
                       rsp_mon.expired_valid, exp_rsp.expired_key, rsp_mon.expired_key);
            end
          end
        end
      end
    end
    pending_cnt_o = rsp_expect_q.size();
  end

endmodule

FILE: tb/tb_hashed_expiry_table_unit.sv
`timescale 1ns / 1ps

module tb_hashed_expiry_table_unit;
  import het_pkg::*;

  localparam int unsigned Buckets       = BucketsDef;
  // after reset the block sweeps all rows before taking a beat, and an update is
  // hashed, read and rewritten; the bound covers both many times over, stalls too
  localparam int unsigned QuietLimit    = 2000;
  localparam int unsigned ItemsPerPhase = 258;
  localparam int unsigned PoolSize      = 32;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  het_in_if  req_if ();
  het_out_if rsp_if ();

  int unsigned     mismatch_cnt;
  int unsigned     pending_cnt;
  int unsigned     src_idle_pct  = 0;
  int unsigned     snk_stall_pct = 0;
  // scans sent so far tell which bucket the next scan visits
  int unsigned     scans_sent    = 0;
  int unsigned     quiet_cycles  = 0;
  logic [KeyW-1:0] key_pool [PoolSize];

  always #2 clk_i = ~clk_i;

  hashed_expiry_table_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  expiry_table_checker chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_mon        (req_if),
    .rsp_mon        (rsp_if),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_cnt_o  (pending_cnt)
  );

  // receiver back-pressure, one draw per cycle
  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // watchdog: ends the run when no beat moves on either channel for too long
  initial begin
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Regression FAIL");
    $finish;
  end

  // one request beat; valid stays high into the next beat unless a gap is drawn
  task automatic send_req(op_e op, logic [KeyW-1:0] k, logic [TimeW-1:0] d);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.opcode   <= op;
    req_if.key      <= k;
    req_if.duration <= d;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (op == OP_SCAN) scans_sent++;
  endtask

  // most often keys already seen, so deletes hit and updates replace; otherwise
  // fresh keys aimed at the buckets the scan reaches next, which fills them
  // up to full; the rest are fully random keys
  function automatic logic [KeyW-1:0] pick_key();
    logic [KeyW-1:0] k;
    int unsigned     sel;
    sel = $urandom_range(99);
    if (sel < 45) return key_pool[$urandom_range(PoolSize - 1)];
    k = $urandom;
    if (sel < 85) begin
      k = k - (k % Buckets) + ((scans_sent + $urandom_range(3)) % Buckets);
      key_pool[$urandom_range(PoolSize - 1)] = k;
    end
    return k;
  endfunction

  task automatic run_phase(int unsigned src_pct, int unsigned snk_pct, int unsigned n_items);
    int unsigned     sel;
    logic [TimeW-1:0] dur;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    for (int unsigned i = 0; i < n_items; i++) begin
      // short durations so entries expire after a few ticks, some that wrap
      // the deadline just below now, and some fully random
      sel = $urandom_range(99);
      if (sel < 70)      dur = $urandom_range(8);
      else if (sel < 85) dur = 32'd0 - $urandom_range(8);
      else               dur = $urandom;
      sel = $urandom_range(99);
      if (sel < 35)      send_req(OP_UPDATE, pick_key(), dur);
      else if (sel < 50) send_req(OP_DELETE, pick_key(), dur);
      else if (sel < 75) send_req(OP_TICK, $urandom, dur);
      else               send_req(OP_SCAN, $urandom, dur);
    end
  endtask

  initial begin
    logic [KeyW-1:0] k;
    req_if.valid    <= 1'b0;
    req_if.opcode   <= OP_TICK;
    req_if.key      <= '0;
    req_if.duration <= '0;
    // seed the key pool with keys in the first few buckets
    for (int unsigned i = 0; i < PoolSize; i++) begin
      k = $urandom;
      key_pool[i] = k - (k % Buckets) + (i % 4);
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part, no idling
    send_req(OP_UPDATE, 32'h0000_0000, 32'h0000_0000);
    send_req(OP_SCAN,   32'h0000_0000, 32'h0000_0000);  // deadline equals now, stays
    send_req(OP_TICK,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // deadline wraps to zero, top bucket
    send_req(OP_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // fill bucket one, then one more is dropped
    send_req(OP_UPDATE, 32'd1,   32'd0);
    send_req(OP_UPDATE, 32'd129, 32'd0);
    send_req(OP_UPDATE, 32'd257, 32'd0);
    send_req(OP_UPDATE, 32'd385, 32'd0);
    send_req(OP_UPDATE, 32'd513, 32'd0);
    // key already in the full bucket: replaced and moved to the back
    send_req(OP_UPDATE, 32'd129, 32'd5);
    send_req(OP_DELETE, 32'd12345, 32'd0);  // not present
    send_req(OP_DELETE, 32'd257, 32'd0);
    send_req(OP_TICK,   32'd0, 32'd0);
    send_req(OP_TICK,   32'd0, 32'd0);
    // bucket one: oldest expired entry goes first
    send_req(OP_SCAN,   32'd0, 32'd0);
    send_req(OP_UPDATE, 32'h8000_0002, 32'd0);
    send_req(OP_SCAN,   32'd0, 32'd0);  // deadline equal to now, not expired
    send_req(OP_DELETE, 32'h0000_0000, 32'd0);
    send_req(OP_UPDATE, 32'h0000_0003, 32'h8000_0000);
    send_req(OP_SCAN,   32'd0, 32'd0);

    // random part over the idling phases
    run_phase(0, 0, ItemsPerPhase);
    run_phase(53, 0, ItemsPerPhase);
    run_phase(0, 53, ItemsPerPhase);
    run_phase(34, 34, ItemsPerPhase);
    req_if.valid <= 1'b0;

    // drain outstanding beats, then wait out anything stray
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
